### design/adrlt_pkg.sv
`timescale 1ns / 1ps

package adrlt_pkg;

    // Accumulator width: holds two tick sizes plus one signed motion value.
    localparam int ACC_W = 18;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TYPE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_CODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_SIZE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_INTERVAL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INSTANCE_INDEX = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_MATCH_TYPE     = 16'd2;
    localparam logic [15:0] RST_MATCH_CODE     = 16'd0;
    localparam logic [14:0] RST_TICK_SIZE      = 15'd1;
    localparam logic [15:0] RST_TAP_INTERVAL   = 16'd0;
    localparam logic [7:0]  RST_INSTANCE_INDEX = 8'd0;

    // Operation codes of an input word.
    localparam logic OP_MOTION = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic [15:0] match_type;
        logic [15:0] match_code;
        logic [14:0] tick_size;
        logic [15:0] tap_interval;
        logic [7:0]  instance_index;
    } t_cfg;

    typedef struct packed {
        logic               operation;
        logic [15:0]        event_type;
        logic [15:0]        event_code;
        logic signed [15:0] event_value;
        logic [7:0]         source_index;
    } t_item;

    typedef struct packed {
        logic       consumed;
        logic       tap_fire;
        logic       tap_direction;
        logic [7:0] tap_source;
        logic [7:0] tap_instance;
    } t_result;

endpackage

### design/adrlt_cfg_regs.sv
`timescale 1ns / 1ps

module adrlt_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [adrlt_pkg::CFG_IDX_W-1:0]     i_wr_index,
    input  logic [adrlt_pkg::CFG_DATA_W-1:0]    i_wr_data,
    output adrlt_pkg::t_cfg                     o_cfg
);
    import adrlt_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match_type     <= RST_MATCH_TYPE;
            r_cfg.match_code     <= RST_MATCH_CODE;
            r_cfg.tick_size      <= RST_TICK_SIZE;
            r_cfg.tap_interval   <= RST_TAP_INTERVAL;
            r_cfg.instance_index <= RST_INSTANCE_INDEX;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_MATCH_TYPE:     r_cfg.match_type     <= i_wr_data;
                CFG_MATCH_CODE:     r_cfg.match_code     <= i_wr_data;
                CFG_TICK_SIZE:      r_cfg.tick_size      <= i_wr_data[14:0];
                CFG_TAP_INTERVAL:   r_cfg.tap_interval   <= i_wr_data;
                CFG_INSTANCE_INDEX: r_cfg.instance_index <= i_wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/adrlt_core.sv
`timescale 1ns / 1ps

module adrlt_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  adrlt_pkg::t_item    i_item,
    input  adrlt_pkg::t_cfg     i_cfg,
    output adrlt_pkg::t_result  o_res
);
    import adrlt_pkg::*;

    logic signed [ACC_W-1:0] r_acc;
    logic                    r_pending;
    logic [15:0]             r_countdown;
    logic [7:0]              r_last_src;

    logic signed [ACC_W-1:0] n_acc;
    logic                    n_pending;
    logic [15:0]             n_countdown;
    logic [7:0]              n_last_src;

    logic signed [ACC_W-1:0] tick;
    logic signed [ACC_W-1:0] neg_tick;
    logic signed [ACC_W-1:0] two_tick;
    logic signed [ACC_W-1:0] neg_two_tick;
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] acc_dec;
    logic signed [ACC_W-1:0] acc_inc;
    logic signed [ACC_W-1:0] remain;
    logic                    match;
    logic                    take_pos;
    logic                    take_neg;
    t_result                 res;

    always_comb begin
        // A tick size of zero behaves as one.
        tick = (i_cfg.tick_size == 15'd0) ? ACC_W'(1) : ACC_W'({1'b0, i_cfg.tick_size});
        neg_tick     = -tick;
        two_tick     = tick <<< 1;
        neg_two_tick = -two_tick;

        sum     = r_acc + ACC_W'(i_item.event_value);
        acc_dec = r_acc - tick;
        acc_inc = r_acc + tick;

        match    = (i_item.event_type == i_cfg.match_type) &&
                   (i_item.event_code == i_cfg.match_code);
        take_pos = (r_acc >= tick);
        take_neg = !take_pos && (r_acc <= neg_tick);
        remain   = take_pos ? acc_dec : acc_inc;
    end

    always_comb begin
        n_acc       = r_acc;
        n_pending   = r_pending;
        n_countdown = r_countdown;
        n_last_src  = r_last_src;
        res         = '0;

        if (i_item.operation == OP_MOTION) begin
            if (match) begin
                if (sum > two_tick) begin
                    n_acc = two_tick;
                end else if (sum < neg_two_tick) begin
                    n_acc = neg_two_tick;
                end else begin
                    n_acc = sum;
                end
                n_last_src = i_item.source_index;
                if (!r_pending) begin
                    n_pending   = 1'b1;
                    n_countdown = i_cfg.tap_interval;
                end
                res.consumed = 1'b1;
            end
        end else if (r_pending) begin
            if (r_countdown > 16'd1) begin
                n_countdown = r_countdown - 16'd1;
            end else begin
                // Timer expired: emit a tap if a full tick size is stored.
                n_pending   = 1'b0;
                n_countdown = '0;
                if (take_pos || take_neg) begin
                    n_acc             = remain;
                    res.tap_fire      = 1'b1;
                    res.tap_direction = take_pos;
                    res.tap_source    = r_last_src;
                    res.tap_instance  = i_cfg.instance_index;
                    if ((remain >= tick) || (remain <= neg_tick)) begin
                        n_pending   = 1'b1;
                        n_countdown = i_cfg.tap_interval;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_pending   <= 1'b0;
            r_countdown <= '0;
            r_last_src  <= '0;
        end else if (i_step) begin
            r_acc       <= n_acc;
            r_pending   <= n_pending;
            r_countdown <= n_countdown;
            r_last_src  <= n_last_src;
        end
    end

    assign o_res = res;

endmodule

### design/axis_delta_to_rate_limited_taps.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_stall     operation, event type/code/value, source
// output    out        o_out_valid / i_out_stall   consumed, tap fire/direction/source/instance
// config    in         i_cfg_valid / o_cfg_ready   register index, write data
//
// Every input word yields exactly one result word: an accepted word is held in the input
// register and then enters the result register, from which it is offered on the output.
// One word per cycle is sustained, so the only limit is the output stall.
// Reset (synchronous, active low) clears the accumulator, the tap timer, the recorded
// source and all valid flags, and loads the configuration defaults.
// While the output is stalled with a full result register, a held input word raises
// o_in_stall; configuration writes are always taken.

module axis_delta_to_rate_limited_taps (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_operation,
    input  logic [15:0]         i_event_type,
    input  logic [15:0]         i_event_code,
    input  logic signed [15:0]  i_event_value,
    input  logic [7:0]          i_source_index,

    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_consumed,
    output logic                o_tap_fire,
    output logic                o_tap_direction,
    output logic [7:0]          o_tap_source,
    output logic [7:0]          o_tap_instance,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [adrlt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [adrlt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import adrlt_pkg::*;

    t_cfg    cfg;
    t_result core_res;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_res;

    logic    out_blocked;
    logic    step;

    // The configuration registers can be written in any cycle.
    assign o_cfg_ready = 1'b1;

    adrlt_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The result register is blocked when it holds a word that the sink stalls.
    // The held input word then cannot move, and neither can a new one enter.
    assign out_blocked = r_out_valid && i_out_stall;
    assign o_in_stall  = r_in_valid && out_blocked;
    assign step        = r_in_valid && !out_blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_item.operation    <= i_operation;
            r_item.event_type   <= i_event_type;
            r_item.event_code   <= i_event_code;
            r_item.event_value  <= i_event_value;
            r_item.source_index <= i_source_index;
        end
    end

    // State update and result for the word in the input register.
    adrlt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_blocked) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_consumed      = r_res.consumed;
    assign o_tap_fire      = r_res.tap_fire;
    assign o_tap_direction = r_res.tap_direction;
    assign o_tap_source    = r_res.tap_source;
    assign o_tap_instance  = r_res.tap_instance;

`ifndef ASSERT_OFF
    // A valid result word is never both consumed and a tap: motion never fires, ticks are never consumed.
    a_fire_not_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_consumed && o_tap_fire))
        else $error("result word is both consumed and a tap");

    // An accepted input word is held in the input register on the next cycle.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_valid)
        else $error("accepted input word was lost");

    // A word waiting behind a stalled result must hold off the source.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_out_stall) |-> (o_in_stall && !step))
        else $error("input word advanced past a stalled result");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for axis_delta_to_rate_limited_taps.
//
// A stimulus process fills a queue of pending input words. A clocked driver takes
// words from that queue at the falling edge and offers them on the input channel.
// A second clocked process drives the output stall. A monitor at the rising edge
// runs its own model of the tap logic on every accepted input word, then checks
// each accepted result word against the oldest expected word.
module tb;
    import adrlt_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 60;
    localparam int REPORT_MAX   = 10;

    // Pacing of the two channels: the slow side idles in most cycles.
    typedef enum {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} t_pace;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;

    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic                   i_operation = OP_MOTION;
    logic [15:0]            i_event_type = '0;
    logic [15:0]            i_event_code = '0;
    logic signed [15:0]     i_event_value = '0;
    logic [7:0]             i_source_index = '0;

    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic                   o_consumed;
    logic                   o_tap_fire;
    logic                   o_tap_direction;
    logic [7:0]             o_tap_source;
    logic [7:0]             o_tap_instance;

    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_MATCH_TYPE;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Model of the block: its own copy of the registers and of the tap state.
    t_cfg                   cfg_model;
    logic signed [ACC_W-1:0] motion_acc;
    bit                     timer_armed;
    logic [15:0]            timer_count;
    logic [7:0]             recorded_source;

    t_item                  pending_words[$];
    t_result                expected_taps[$];

    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    bit                     pressure_armed = 1'b0;
    bit                     pressure_used = 1'b0;
    int                     hold_left = 0;
    int                     mismatches = 0;
    int                     cycle_count = 0;
    bit                     in_taken = 1'b0;

    axis_delta_to_rate_limited_taps u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_event_type    (i_event_type),
        .i_event_code    (i_event_code),
        .i_event_value   (i_event_value),
        .i_source_index  (i_source_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_consumed      (o_consumed),
        .o_tap_fire      (o_tap_fire),
        .o_tap_direction (o_tap_direction),
        .o_tap_source    (o_tap_source),
        .o_tap_instance  (o_tap_instance),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin : clock_gen
        forever #6 i_clk = ~i_clk;
    end

    // Works out the result word of one input word and advances the model state.
    // A matching motion word folds its value into the accumulator, clamped to two
    // tick sizes either way, and arms the timer only if it is not already running.
    // A tick counts a running timer down; on expiry, if a whole tick size is stored,
    // one tick size leaves the accumulator and one tap goes out toward its sign,
    // and the timer re-arms while a whole tick size is still stored.
    function automatic t_result predict_taps(input t_item it);
        t_result r;
        int      step;
        int      sum;
        r = '0;
        step = (cfg_model.tick_size == '0) ? 1 : int'(cfg_model.tick_size);
        if (it.operation == OP_MOTION) begin
            if (it.event_type != cfg_model.match_type ||
                    it.event_code != cfg_model.match_code) begin
                return r;
            end
            sum = int'(motion_acc) + int'($signed(it.event_value));
            if (sum > 2 * step) begin
                sum = 2 * step;
            end else if (sum < -2 * step) begin
                sum = -2 * step;
            end
            motion_acc = sum[ACC_W-1:0];
            recorded_source = it.source_index;
            if (!timer_armed) begin
                timer_armed = 1'b1;
                timer_count = cfg_model.tap_interval;
            end
            r.consumed = 1'b1;
            return r;
        end
        if (!timer_armed) begin
            return r;
        end
        if (timer_count > 16'd1) begin
            timer_count = timer_count - 16'd1;
            return r;
        end
        // The timer has run out: it stops unless a tap leaves enough behind.
        timer_armed = 1'b0;
        timer_count = '0;
        sum = int'(motion_acc);
        if (sum >= step) begin
            sum = sum - step;
            r.tap_direction = 1'b1;
        end else if (sum <= -step) begin
            sum = sum + step;
        end else begin
            return r;
        end
        motion_acc = sum[ACC_W-1:0];
        r.tap_fire = 1'b1;
        r.tap_source = recorded_source;
        r.tap_instance = cfg_model.instance_index;
        if (sum >= step || sum <= -step) begin
            timer_armed = 1'b1;
            timer_count = cfg_model.tap_interval;
        end
        return r;
    endfunction

    function automatic t_item motion_word(input logic [15:0] ty, input logic [15:0] code,
                                          input logic signed [15:0] value,
                                          input logic [7:0] src);
        t_item it;
        it.operation = OP_MOTION;
        it.event_type = ty;
        it.event_code = code;
        it.event_value = value;
        it.source_index = src;
        return it;
    endfunction

    // A tick carries random junk in the event fields, which the block ignores.
    function automatic t_item tick_word();
        t_item it;
        it = motion_word(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
        it.operation = OP_TICK;
        return it;
    endfunction

    // Mostly well-formed traffic: matching motion and ticks in roughly equal
    // measure, with some motion words that miss on type, code or both.
    function automatic t_item random_word(input logic [15:0] ty, input logic [15:0] code,
                                          input logic [14:0] tick);
        t_item              it;
        logic signed [15:0] value;
        int                 step;
        int                 span;
        int                 pick;
        step = (tick == '0) ? 1 : int'(tick);
        span = (2 * step + 2 > 32767) ? 32767 : 2 * step + 2;
        case ($urandom_range(0, 7))
            0: begin
                value = 16'($urandom);
            end
            1: begin
                value = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end
            default: begin
                value = 16'(int'($urandom_range(0, 2 * span)) - span);
            end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            it = tick_word();
        end else if (pick < 90) begin
            it = motion_word(ty, code, value, 8'($urandom));
        end else begin
            it = motion_word(16'($urandom), 16'($urandom), value, 8'($urandom));
            case ($urandom_range(0, 2))
                0: it.event_type = ty;
                1: it.event_code = code;
                default: ;
            endcase
        end
        return it;
    endfunction

    // Input driver: a word stays on the port until it is taken. A new word is
    // only considered once the port is free, so idling never depends on stall.
    always @(negedge i_clk) begin : drive_input
        t_item word;
        logic  next_valid;
        next_valid = i_in_valid && !in_taken;
        if (!next_valid && pending_words.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
            word = pending_words.pop_front();
            i_operation <= word.operation;
            i_event_type <= word.event_type;
            i_event_code <= word.event_code;
            i_event_value <= word.event_value;
            i_source_index <= word.source_index;
            next_valid = 1'b1;
        end
        i_in_valid <= next_valid;
    end

    // Output stall. Once per run, when asked, the receiver holds off for a long
    // stretch so that the block fills up and pushes back on its input.
    always @(negedge i_clk) begin : drive_output_stall
        if (pressure_armed && !pressure_used) begin
            pressure_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Monitor: follows register writes and accepted input words in the model,
    // and checks every accepted result word against the oldest expectation.
    always @(posedge i_clk) begin : watch
        t_item   seen;
        t_result got;
        t_result want;
        cycle_count = cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end else begin
            in_taken <= i_rst_n && i_in_valid && !o_in_stall;
            if (!i_rst_n) begin
                cfg_model.match_type = RST_MATCH_TYPE;
                cfg_model.match_code = RST_MATCH_CODE;
                cfg_model.tick_size = RST_TICK_SIZE;
                cfg_model.tap_interval = RST_TAP_INTERVAL;
                cfg_model.instance_index = RST_INSTANCE_INDEX;
                motion_acc = '0;
                timer_armed = 1'b0;
                timer_count = '0;
                recorded_source = '0;
            end else begin
                if (i_cfg_valid && o_cfg_ready) begin
                    case (i_cfg_index)
                        CFG_MATCH_TYPE:     cfg_model.match_type = i_cfg_data;
                        CFG_MATCH_CODE:     cfg_model.match_code = i_cfg_data;
                        CFG_TICK_SIZE:      cfg_model.tick_size = i_cfg_data[14:0];
                        CFG_TAP_INTERVAL:   cfg_model.tap_interval = i_cfg_data;
                        CFG_INSTANCE_INDEX: cfg_model.instance_index = i_cfg_data[7:0];
                        default: ;
                    endcase
                end
                if (i_in_valid && !o_in_stall) begin
                    seen = motion_word(i_event_type, i_event_code, i_event_value,
                                       i_source_index);
                    seen.operation = i_operation;
                    expected_taps.push_back(predict_taps(seen));
                end
                if (o_out_valid && !i_out_stall) begin
                    got.consumed = o_consumed;
                    got.tap_fire = o_tap_fire;
                    got.tap_direction = o_tap_direction;
                    got.tap_source = o_tap_source;
                    got.tap_instance = o_tap_instance;
                    if (expected_taps.size() == 0) begin
                        if (mismatches < REPORT_MAX) begin
                            $display("unexpected result word: consumed=%0b fire=%0b dir=%0b src=%02h inst=%02h",
                                     got.consumed, got.tap_fire, got.tap_direction,
                                     got.tap_source, got.tap_instance);
                        end
                        mismatches = mismatches + 1;
                    end else begin
                        want = expected_taps.pop_front();
                        if (got.consumed !== want.consumed ||
                                got.tap_fire !== want.tap_fire ||
                                got.tap_direction !== want.tap_direction ||
                                got.tap_source !== want.tap_source ||
                                got.tap_instance !== want.tap_instance) begin
                            if (mismatches < REPORT_MAX) begin
                                $display("result mismatch: expected consumed=%0b fire=%0b dir=%0b src=%02h inst=%02h",
                                         want.consumed, want.tap_fire, want.tap_direction,
                                         want.tap_source, want.tap_instance);
                                $display("                 got      consumed=%0b fire=%0b dir=%0b src=%02h inst=%02h",
                                         got.consumed, got.tap_fire, got.tap_direction,
                                         got.tap_source, got.tap_instance);
                            end
                            mismatches = mismatches + 1;
                        end
                    end
                end
            end
        end
    end

    // One register write on the configuration channel.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] ty, input logic [15:0] code,
                             input logic [14:0] tick, input logic [15:0] interval,
                             input logic [7:0] inst);
        write_reg(CFG_MATCH_TYPE, ty);
        write_reg(CFG_MATCH_CODE, code);
        write_reg(CFG_TICK_SIZE, {1'b0, tick});
        write_reg(CFG_TAP_INTERVAL, interval);
        write_reg(CFG_INSTANCE_INDEX, {8'h00, inst});
    endtask

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_SLOW_SINK: begin
                send_idle_pct = 23;
                recv_idle_pct = 72;
            end
            PACE_SLOW_SOURCE: begin
                send_idle_pct = 72;
                recv_idle_pct = 23;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Waits until every queued word has been offered and taken and every
    // expected result has come back, then lets the pipeline drain.
    task automatic wait_quiet();
        @(posedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || expected_taps.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input t_pace pace, input int count, input bit squeeze,
                             input logic [15:0] ty, input logic [15:0] code,
                             input logic [14:0] tick);
        @(posedge i_clk);
        set_pace(pace);
        pressure_armed = squeeze;
        for (int n = 0; n < count; n++) begin
            pending_words.push_back(random_word(ty, code, tick));
        end
        wait_quiet();
    endtask

    initial begin : stimulus
        logic [15:0] rand_type;
        logic [15:0] rand_code;
        logic [14:0] rand_tick;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: tick size 3 and a two-tick interval, so that clamping,
        // the rate limit and expiry without a full tick size are easy to follow.
        configure(16'd2, 16'd0, 15'd3, 16'd2, 8'hA5);
        @(posedge i_clk);
        set_pace(PACE_SLOW_SINK);
        // Largest positive motion clamps to two tick sizes and arms the timer.
        pending_words.push_back(motion_word(16'd2, 16'd0, 16'sh7FFF, 8'hFF));
        // Count down, then a positive tap that leaves a full tick size, so the
        // timer re-arms; the second expiry empties the accumulator.
        repeat (4) pending_words.push_back(tick_word());
        // A tick with no timer running does nothing.
        pending_words.push_back(tick_word());
        // Motion that misses on type, on code, and on both at the low extreme.
        pending_words.push_back(motion_word(16'hFFFF, 16'd0, 16'sd5, 8'h11));
        pending_words.push_back(motion_word(16'd2, 16'hFFFF, 16'sd5, 8'h22));
        pending_words.push_back(motion_word(16'h0000, 16'h0001, 16'sh7FFF, 8'h33));
        // Largest negative motion clamps low; the next motion finds the timer
        // already running and does not restart it.
        pending_words.push_back(motion_word(16'd2, 16'd0, 16'sh8000, 8'h00));
        pending_words.push_back(motion_word(16'd2, 16'd0, 16'sd5, 8'h5A));
        // Expiry with less than a tick size stored: no tap, timer stops.
        repeat (2) pending_words.push_back(tick_word());
        // A negative tap.
        pending_words.push_back(motion_word(16'd2, 16'd0, -16'sd4, 8'h3C));
        repeat (2) pending_words.push_back(tick_word());
        // Zero motion still arms the timer, which then expires with nothing.
        pending_words.push_back(motion_word(16'd2, 16'd0, 16'sd0, 8'h81));
        repeat (3) pending_words.push_back(tick_word());
        wait_quiet();

        // Zero interval: each armed timer expires on the very next tick.
        rand_type = 16'($urandom);
        rand_code = 16'($urandom);
        rand_tick = 15'($urandom_range(1, 40));
        configure(rand_type, rand_code, rand_tick, 16'd0, 8'hFF);
        run_phase(PACE_SLOW_SINK, 300, 1'b0, rand_type, rand_code, rand_tick);

        // Largest tick size with a one-tick interval.
        configure(16'hFFFF, 16'hFFFF, 15'h7FFF, 16'd1, 8'h00);
        run_phase(PACE_SLOW_SOURCE, 300, 1'b0, 16'hFFFF, 16'hFFFF, 15'h7FFF);

        // Zero tick size behaves as one; full rate, with one long output hold-off.
        rand_code = 16'($urandom);
        configure(16'h0000, rand_code, 15'd0, 16'd5, 8'h3C);
        run_phase(PACE_FULL, 250, 1'b1, 16'h0000, rand_code, 15'd0);

        // Longest interval: the timer stays pending for the whole phase.
        configure(16'hFFFF, 16'h0000, 15'd1, 16'hFFFF, 8'h81);
        run_phase(PACE_FULL, 40, 1'b0, 16'hFFFF, 16'h0000, 15'd1);

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_taps.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### axis_delta_to_rate_limited_taps.f
design/adrlt_pkg.sv
design/adrlt_cfg_regs.sv
design/adrlt_core.sv
design/axis_delta_to_rate_limited_taps.sv
tb/tb.sv
